/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, clocked on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/ird_pkg.sv */
package ird_pkg;

  localparam int STAMP_W        = 16;
  localparam int EDGE_COUNT_DEF = 31;
  localparam int CAT_IDX_W      = 5;

  // x / 3 == (x * 0xAAAB) >> 17 for x below 2^17
  localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
  localparam int          DIV3_SHIFT = 17;
  localparam int          MARGIN_IN_W = STAMP_W - 2;
  localparam int          PROD_W      = MARGIN_IN_W + 16;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SPAN,
    ST_DIV,
    ST_WIDEN,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_PULSE,
    RK_GAP,
    RK_FINAL
  } rd_kind_t;

  typedef enum logic [2:0] {
    CAT_NONE,
    CAT_ONE,
    CAT_ZERO,
    CAT_SMALL,
    CAT_LARGE
  } win_cat_t;

  typedef struct packed {
    logic     take_first;
    logic     take_edge;
    logic     div;
    logic     widen;
    logic     rd_en;
    rd_kind_t rd_kind;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // which timing window a training interval feeds
  function automatic win_cat_t cat_of(input logic [CAT_IDX_W-1:0] idx);
    win_cat_t c;
    unique case (idx) inside
      5'd1, 5'd3, 5'd7, 5'd9: c = CAT_ONE;
      5'd5, 5'd11:            c = CAT_ZERO;
      5'd2, 5'd4, 5'd8, 5'd10: c = CAT_SMALL;
      5'd6, 5'd12:            c = CAT_LARGE;
      default:                c = CAT_NONE;
    endcase
    return c;
  endfunction

  function automatic logic in_win(input stamp_t v, input stamp_t lo, input stamp_t hi);
    return (lo <= v) && (v <= hi);
  endfunction

endpackage

/* design/ird_if.sv */
interface ird_in_if;
  import ird_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t edge_stamp;

  modport source (output valid, output edge_stamp, input ready);
  modport sink   (input valid, input edge_stamp, output ready);
endinterface

interface ird_out_if;
  import ird_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t code;
  logic   frame_ok;
  stamp_t idle_timeout;

  modport source (output valid, output code, output frame_ok, output idle_timeout,
                  input ready);
  modport sink   (input valid, input code, input frame_ok, input idle_timeout,
                  output ready);
endinterface

/* design/ird_ctrl.sv */
module ird_ctrl #(
  parameter int EDGE_COUNT = ird_pkg::EDGE_COUNT_DEF,
  parameter int IDX_W      = $clog2(EDGE_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [IDX_W-1:0]  wr_idx,
  output logic [IDX_W-1:0]  rd_addr,
  output ird_pkg::dp_cmd_t  cmd,
  input  ird_pkg::dp_sts_t  sts
);
  import ird_pkg::*;

  localparam logic [IDX_W-1:0] LAST_EDGE = IDX_W'(EDGE_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_GAP  = IDX_W'(((EDGE_COUNT - 1) / 2) * 2);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= '0;
      addr_r  <= IDX_W'(1);
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      addr_r  <= addr_nxt;
      final_r <= final_nxt;
    end
  end

  assign wr_idx  = cnt_r;
  assign rd_addr = final_r ? LAST_EDGE : addr_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    final_nxt = final_r;
    in_ready  = 1'b0;
    cmd       = '{default: '0, rd_kind: RK_NONE};
    unique case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r == '0) begin
            cmd.take_first = 1'b1;
            cnt_nxt        = IDX_W'(1);
          end else begin
            cmd.take_edge = 1'b1;
            if (cnt_r == LAST_EDGE) begin
              cnt_nxt   = '0;
              state_nxt = ST_SPAN;
            end else begin
              cnt_nxt = cnt_r + IDX_W'(1);
            end
          end
        end
      end
      // last interval is written to the interval memory this cycle
      ST_SPAN: state_nxt = ST_DIV;
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_WIDEN;
      end
      ST_WIDEN: begin
        cmd.widen = 1'b1;
        addr_nxt  = IDX_W'(1);
        final_nxt = 1'b0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.rd_en = 1'b1;
        if (final_r) begin
          cmd.rd_kind = RK_FINAL;
          final_nxt   = 1'b0;
          state_nxt   = ST_DRAIN;
        end else begin
          cmd.rd_kind = addr_r[0] ? RK_PULSE : RK_GAP;
          if (addr_r == LAST_GAP) begin
            final_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

endmodule

/* design/ird_dp.sv */
module ird_dp #(
  parameter int EDGE_COUNT = ird_pkg::EDGE_COUNT_DEF,
  parameter int IDX_W      = $clog2(EDGE_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ird_pkg::stamp_t   edge_stamp,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [IDX_W-1:0]  rd_addr,
  input  ird_pkg::dp_cmd_t  cmd,
  output ird_pkg::dp_sts_t  sts,
  ird_out_if.source         out_bus
);
  import ird_pkg::*;

  stamp_t           mem [EDGE_COUNT];
  stamp_t           prev_r, iv_r, rd_data_r;
  logic [IDX_W-1:0] iv_idx_r;
  logic             iv_vld_r;
  rd_kind_t         kind_r;

  stamp_t o_min_r, o_max_r, z_min_r, z_max_r;
  stamp_t s_min_r, s_max_r, l_min_r, l_max_r;
  logic [PROD_W-1:0] mult_r;
  stamp_t o_lo_r, o_hi_r, z_lo_r, z_hi_r, s_lo_r, s_hi_r, l_lo_r, l_hi_r;
  stamp_t twice_r;

  logic   one_hit_r, zero_hit_r, ok_r;
  stamp_t code_r;

  logic   out_valid_r, out_ok_r;
  stamp_t out_code_r, out_to_r;

  stamp_t    diff, iv_new, margin, o_hi_w;
  logic [STAMP_W:0] dbl;
  win_cat_t  cat;

  // wrap rule: not greater means 0xFFFF - prev + cur, one less than cur - prev
  assign diff   = edge_stamp - prev_r;
  assign iv_new = (edge_stamp > prev_r) ? diff : diff - 16'd1;
  assign cat    = cat_of(CAT_IDX_W'(iv_idx_r));

  assign margin = STAMP_W'(mult_r[PROD_W-1:DIV3_SHIFT]);
  assign o_hi_w = o_max_r + margin;
  assign dbl    = {o_hi_w, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_vld_r <= 1'b0;
      kind_r   <= RK_NONE;
    end else begin
      iv_vld_r <= cmd.take_edge;
      kind_r   <= cmd.rd_en ? cmd.rd_kind : RK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_first || cmd.take_edge) begin
      prev_r <= edge_stamp;
    end
    if (cmd.take_edge) begin
      iv_r     <= iv_new;
      iv_idx_r <= wr_idx;
    end
    if (iv_vld_r) begin
      mem[iv_idx_r] <= iv_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // window spans learned while the training intervals arrive
  always_ff @(posedge clk) begin
    if (cmd.take_first) begin
      o_min_r <= STAMP_MAX;  o_max_r <= '0;
      z_min_r <= STAMP_MAX;  z_max_r <= '0;
      s_min_r <= STAMP_MAX;  s_max_r <= '0;
      l_min_r <= STAMP_MAX;  l_max_r <= '0;
    end else if (iv_vld_r) begin
      case (cat)
        CAT_ONE: begin
          if (iv_r < o_min_r) o_min_r <= iv_r;
          if (iv_r > o_max_r) o_max_r <= iv_r;
        end
        CAT_ZERO: begin
          if (iv_r < z_min_r) z_min_r <= iv_r;
          if (iv_r > z_max_r) z_max_r <= iv_r;
        end
        CAT_SMALL: begin
          if (iv_r < s_min_r) s_min_r <= iv_r;
          if (iv_r > s_max_r) s_max_r <= iv_r;
        end
        CAT_LARGE: begin
          if (iv_r < l_min_r) l_min_r <= iv_r;
          if (iv_r > l_max_r) l_max_r <= iv_r;
        end
        default: ;
      endcase
    end
  end

  // margin = one max / 12 = (one max / 4) / 3
  always_ff @(posedge clk) begin
    if (cmd.div) begin
      mult_r <= PROD_W'(o_max_r[STAMP_W-1:2]) * PROD_W'(DIV3_RECIP);
    end
    if (cmd.widen) begin
      o_lo_r  <= o_min_r - margin;  o_hi_r <= o_hi_w;
      z_lo_r  <= z_min_r - margin;  z_hi_r <= z_max_r + margin;
      s_lo_r  <= s_min_r - margin;  s_hi_r <= s_max_r + margin;
      l_lo_r  <= l_min_r - margin;  l_hi_r <= l_max_r + margin;
      twice_r <= dbl[STAMP_W] ? STAMP_MAX : dbl[STAMP_W-1:0];
    end
  end

  // classification walk, one stored interval per cycle
  always_ff @(posedge clk) begin
    if (cmd.widen) begin
      code_r <= '0;
      ok_r   <= 1'b1;
    end else begin
      case (kind_r)
        RK_PULSE: begin
          one_hit_r  <= in_win(rd_data_r, o_lo_r, o_hi_r);
          zero_hit_r <= in_win(rd_data_r, z_lo_r, z_hi_r);
        end
        RK_GAP: begin
          if (one_hit_r && in_win(rd_data_r, s_lo_r, s_hi_r)) begin
            code_r <= {code_r[STAMP_W-2:0], 1'b1};
          end else if (zero_hit_r && in_win(rd_data_r, l_lo_r, l_hi_r)) begin
            code_r <= {code_r[STAMP_W-2:0], 1'b0};
          end else begin
            ok_r <= 1'b0;
          end
        end
        RK_FINAL: begin
          if (in_win(rd_data_r, o_lo_r, o_hi_r)) begin
            code_r <= {code_r[STAMP_W-2:0], 1'b1};
          end else if (in_win(rd_data_r, z_lo_r, z_hi_r)) begin
            code_r <= {code_r[STAMP_W-2:0], 1'b0};
          end else begin
            ok_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register, holds until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_code_r <= ok_r ? code_r : '0;
      out_ok_r   <= ok_r;
      out_to_r   <= twice_r;
    end
  end

  assign sts.out_free         = !out_valid_r || out_bus.ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.code         = out_code_r;
  assign out_bus.frame_ok     = out_ok_r;
  assign out_bus.idle_timeout = out_to_r;

endmodule

/* design/ir_adaptive_pulse_decoder.sv */
// Adaptive IR pulse-distance decoder. Each frame is EDGE_COUNT edge stamps on in_bus; every
// stamp of a frame is taken as soon as it is valid; the first only starts the interval chain. The
// timing windows are learned from intervals 1 to 12 as they arrive. After the last edge of a
// frame the input stalls while the stored intervals are walked through the single read port
// of the interval memory, one per cycle, and while the previous result waits to be taken.
// One result per frame then appears on out_bus with code (0 for a bad frame), frame_ok and
// idle_timeout, held until taken while the next frame's edges are accepted.
`include "assert_macros.svh"

module ir_adaptive_pulse_decoder #(
  parameter int EDGE_COUNT = ird_pkg::EDGE_COUNT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ird_in_if.sink      in_bus,
  ird_out_if.source   out_bus
);
  import ird_pkg::*;

  localparam int IDX_W = $clog2(EDGE_COUNT);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] wr_idx, rd_addr;
  logic             in_ready;

  assign in_bus.ready = in_ready;

  ird_ctrl #(
    .EDGE_COUNT (EDGE_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .wr_idx   (wr_idx),
    .rd_addr  (rd_addr),
    .cmd      (cmd),
    .sts      (sts)
  );

  ird_dp #(
    .EDGE_COUNT (EDGE_COUNT),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_stamp (in_bus.edge_stamp),
    .wr_idx     (wr_idx),
    .rd_addr    (rd_addr),
    .cmd        (cmd),
    .sts        (sts),
    .out_bus    (out_bus)
  );

  `ASSERT_IMPLIES(a_no_take_during_walk, cmd.rd_en, !in_bus.ready)
  `ASSERT_IMPLIES(a_load_into_free_slot, cmd.load_out, sts.out_free)
  `ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_bus.valid)
  `ASSERT_IMPLIES(a_bad_frame_zero_code, out_bus.valid && !out_bus.frame_ok, out_bus.code == 16'd0)

endmodule

/* dv/ir_adaptive_pulse_decoder_tb.sv */
`timescale 1ns / 100ps

module ir_adaptive_pulse_decoder_tb;
  import ird_pkg::*;

  localparam int EDGES      = EDGE_COUNT_DEF;
  localparam int EDGE_ITEMS = 1450;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_WAIT  = 64;
  localparam int MAX_PRINT  = 40;

  typedef struct packed {
    stamp_t code;
    logic   frame_ok;
    stamp_t idle_timeout;
  } frame_result_t;

  // shadow of the decoder: intervals, last stamp and edge position, plus awaited results
  class frame_decode_scoreboard;
    stamp_t        iv_seen [EDGES];
    stamp_t        last_stamp;
    int            edge_pos;
    frame_result_t awaited[$];
    int            mismatches;
    int            frames_ok;
    int            frames_bad;

    function new();
      last_stamp = '0;
      edge_pos   = 0;
      mismatches = 0;
      frames_ok  = 0;
      frames_bad = 0;
      foreach (iv_seen[k]) iv_seen[k] = '0;
    endfunction

    function stamp_t min2(stamp_t a, stamp_t b);
      return (a < b) ? a : b;
    endfunction

    function stamp_t max2(stamp_t a, stamp_t b);
      return (a > b) ? a : b;
    endfunction

    function logic in_span(stamp_t v, stamp_t lo, stamp_t hi);
      return (lo <= v) && (v <= hi);
    endfunction

    function frame_result_t decode_frame();
      stamp_t        o_lo, o_hi, z_lo, z_hi, s_lo, s_hi, l_lo, l_hi, margin, v;
      logic [16:0]   dbl;
      stamp_t        bits;
      logic          ok;
      frame_result_t r;
      o_lo = min2(min2(iv_seen[1], iv_seen[3]), min2(iv_seen[7], iv_seen[9]));
      o_hi = max2(max2(iv_seen[1], iv_seen[3]), max2(iv_seen[7], iv_seen[9]));
      z_lo = min2(iv_seen[5], iv_seen[11]);
      z_hi = max2(iv_seen[5], iv_seen[11]);
      s_lo = min2(min2(iv_seen[2], iv_seen[4]), min2(iv_seen[8], iv_seen[10]));
      s_hi = max2(max2(iv_seen[2], iv_seen[4]), max2(iv_seen[8], iv_seen[10]));
      l_lo = min2(iv_seen[6], iv_seen[12]);
      l_hi = max2(iv_seen[6], iv_seen[12]);
      // windows widen by a twelfth of the one-pulse max, wrapping at 16 bits
      margin = o_hi / 16'd12;
      o_hi = o_hi + margin;  o_lo = o_lo - margin;
      z_hi = z_hi + margin;  z_lo = z_lo - margin;
      s_hi = s_hi + margin;  s_lo = s_lo - margin;
      l_hi = l_hi + margin;  l_lo = l_lo - margin;
      dbl  = {o_hi, 1'b0};
      bits = '0;
      ok   = 1'b1;
      for (int i = 1; i < EDGES - 1 && ok; i += 2) begin
        if (in_span(iv_seen[i], o_lo, o_hi) && in_span(iv_seen[i+1], s_lo, s_hi)) begin
          bits = {bits[14:0], 1'b1};
        end else if (in_span(iv_seen[i], z_lo, z_hi) && in_span(iv_seen[i+1], l_lo, l_hi)) begin
          bits = {bits[14:0], 1'b0};
        end else begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        v = iv_seen[EDGES-1];
        if (in_span(v, o_lo, o_hi)) begin
          bits = {bits[14:0], 1'b1};
        end else if (in_span(v, z_lo, z_hi)) begin
          bits = {bits[14:0], 1'b0};
        end else begin
          ok = 1'b0;
        end
      end
      r.code         = ok ? bits : '0;
      r.frame_ok     = ok;
      r.idle_timeout = dbl[16] ? STAMP_MAX : dbl[15:0];
      return r;
    endfunction

    function void note_edge(stamp_t s);
      stamp_t iv;
      if (edge_pos == 0) begin
        last_stamp = s;
        edge_pos   = 1;
        return;
      end
      // a stamp at or below the previous one is a timer wrap
      if (s > last_stamp) iv = s - last_stamp;
      else iv = (STAMP_MAX - last_stamp) + s;
      iv_seen[edge_pos] = iv;
      last_stamp = s;
      edge_pos++;
      if (edge_pos >= EDGES) begin
        edge_pos = 0;
        awaited.push_back(decode_frame());
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINT) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_frame(frame_result_t got);
      frame_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with no frame pending, code %h", got.code));
        return;
      end
      want = awaited.pop_front();
      if (want.frame_ok) frames_ok++;
      else frames_bad++;
      if (got.code !== want.code)
        report_mismatch($sformatf("code %h, expected %h", got.code, want.code));
      if (got.frame_ok !== want.frame_ok)
        report_mismatch($sformatf("frame_ok %b, expected %b", got.frame_ok, want.frame_ok));
      if (got.idle_timeout !== want.idle_timeout)
        report_mismatch($sformatf("idle_timeout %h, expected %h",
                                  got.idle_timeout, want.idle_timeout));
    endtask
  endclass

  logic clk;
  logic rst_n;

  ird_in_if  in_bus ();
  ird_out_if out_bus ();

  ir_adaptive_pulse_decoder #(.EDGE_COUNT(EDGES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  frame_decode_scoreboard sb;
  stamp_t frame_plan [EDGES];
  int     edges_sent;
  int     idle_cycles;
  bit     in_burst;
  bit     out_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stamp_t jittered(int base, int jit);
    int v;
    v = base + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // bit_mode: 0 random payload, 1 all ones, 2 all zeros; training pairs are 1,1,0,1,1,0
  task automatic plan_clean(int t1, int t0, int gs, int gl, int jit, int bit_mode);
    bit b;
    for (int i = 1; i < EDGES; i += 2) begin
      case ((i - 1) / 2)
        0, 1, 3, 4: b = 1'b1;
        2, 5:       b = 1'b0;
        default: begin
          if (bit_mode == 1) b = 1'b1;
          else if (bit_mode == 2) b = 1'b0;
          else b = 1'($urandom_range(0, 1));
        end
      endcase
      frame_plan[i] = jittered(b ? t1 : t0, jit);
      if (i + 1 < EDGES) frame_plan[i+1] = jittered(b ? gs : gl, jit);
    end
  endtask

  task automatic send_stamp(stamp_t s);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.edge_stamp = s;
    do @(posedge clk); while (!in_bus.ready);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(stamp_t start);
    stamp_t s;
    s = start;
    in_burst = ($urandom_range(0, 3) == 0);
    send_stamp(s);
    for (int i = 1; i < EDGES; i++) begin
      s = s + frame_plan[i];
      send_stamp(s);
    end
  endtask

  task automatic random_frame();
    int r, t1, t0, gs, gl, jit;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) t1 = $urandom_range(8000, 40000);
    else t1 = $urandom_range(20, 2500);
    t0  = t1 + t1 * $urandom_range(1, 3) / 2;
    gs  = ($urandom_range(0, 2) == 0) ? t1 : t1 + $urandom_range(0, t1);
    gl  = ($urandom_range(0, 3) == 0) ? t0 : t0 + t1;
    if (t0 > 65000) t0 = 65000;
    if (gl > 65000) gl = 65000;
    jit = ($urandom_range(0, 3) == 0) ? 0 : t1 / 30;
    if (r < 20) begin
      plan_clean(t1, t0, gs, gl, jit, 0);
      frame_plan[$urandom_range(1, EDGES - 1)] = stamp_t'($urandom_range(0, 65535));
    end else if (r < 30) begin
      foreach (frame_plan[i]) begin
        if ($urandom_range(0, 7) == 0) frame_plan[i] = '0;
        else frame_plan[i] = stamp_t'($urandom_range(0, 65535));
      end
    end else begin
      plan_clean(t1, t0, gs, gl, jit, $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0);
    end
    send_frame(stamp_t'($urandom_range(0, 65535)));
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    out_burst     = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) out_burst = ~out_burst;
      if (hold > 0) begin
        out_bus.ready = 1'b0;
        hold--;
      end else begin
        out_bus.ready = 1'b1;
        if (!out_burst && $urandom_range(0, 2) == 0) hold = pick_gap(1'b0);
      end
    end
  end

  // beat monitor and no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_edge(in_bus.edge_stamp);
      if (out_bus.valid && out_bus.ready)
        sb.check_frame('{out_bus.code, out_bus.frame_ok, out_bus.idle_timeout});
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("ir_adaptive_pulse_decoder regression: fail");
        $finish;
      end
    end
  end

  initial begin
    sb                = new();
    edges_sent        = 0;
    idle_cycles       = 0;
    in_burst          = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.edge_stamp = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // long timings near the top of the range, timeout saturates, stamps wrap
    plan_clean(40000, 52000, 40000, 60000, 300, 0);
    send_frame(16'hFFF0);
    // all payload bits one, final gap matches the one pulse
    plan_clean(560, 1120, 560, 1690, 10, 1);
    send_frame(16'h0000);
    // all payload bits zero, final large gap inside the zero window
    plan_clean(600, 1500, 700, 1500, 15, 2);
    send_frame(16'h8000);
    // equal stamps: every interval reads as 65535, windows wrap empty
    foreach (frame_plan[i]) frame_plan[i] = '0;
    send_frame(16'h5A5A);
    // one tiny training pulse drags the one window below zero
    plan_clean(12000, 24000, 12000, 30000, 0, 0);
    frame_plan[1] = 16'd1;
    send_frame(16'hA5A5);
    // smallest intervals, zero margin
    plan_clean(1, 2, 1, 3, 0, 0);
    send_frame(16'h7FFF);

    while (edges_sent < EDGE_ITEMS) random_frame();
    in_bus.valid = 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d edge beats in %0d frames", edges_sent, edges_sent / EDGES);
    $display("checked %0d valid and %0d rejected frames, %0d mismatches",
             sb.frames_ok, sb.frames_bad, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("ir_adaptive_pulse_decoder regression: pass");
    end else begin
      $display("ir_adaptive_pulse_decoder regression: fail");
    end
    $finish;
  end

endmodule
